>>> src/mte_pkg.sv
// Shared types, constants and helper functions for the MIDI track event encoder.
// Depends on nothing; used by mte_event_pack and midi_track_event_encoder.
`timescale 1ns / 1ps

package mte_pkg;

	// Most bytes one event can produce: five delta bytes plus status, note, velocity.
	localparam int MaxBytes = 8;
	localparam int CntW     = $clog2(MaxBytes + 1);
	localparam int NumDrum  = 7;

	// Configuration register indexes
	localparam logic [2:0] REG_ENABLE     = 3'd0;
	localparam logic [2:0] REG_DRUM_FIRST = 3'd1;

	localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
	localparam logic [7:0] DRUM_CHANNEL    = 8'd9;
	localparam logic [7:0] NOTE_DEFAULT    = 8'd60;
	localparam logic [7:0] NOTE_MAX        = 8'd99;
	localparam logic [7:0] DRUM_NONE       = 8'hff;
	localparam logic [2:0] AMP_MAX         = 3'd6;

	typedef logic [NumDrum-1:0][7:0] drum_notes_t;
	typedef logic [MaxBytes-1:0][7:0] byte_vec_t;

	// Drum note bytes after reset, colors 0 to 6
	localparam drum_notes_t DRUM_RESET = {8'd39, 8'd62, 8'd42, 8'd46, 8'd38, 8'd47, 8'd36};

	typedef struct packed {
		logic [7:0]         status_base;
		logic [3:0]         color;
		logic               sampled;
		logic signed [31:0] event_time;
		logic signed [7:0]  note_number;
		logic [2:0]         amplitude;
	} item_t;

	typedef struct packed {
		byte_vec_t         bytes;
		logic [CntW-1:0]   cnt;
	} pack_t;

	// Velocity byte for a saturated loudness index
	function automatic logic [7:0] velocity(input logic [2:0] amp);
		logic [7:0] v;
		case (amp)
			3'd0:    v = 8'h00;
			3'd1:    v = 8'h20;
			3'd2:    v = 8'h30;
			3'd3:    v = 8'h40;
			3'd4:    v = 8'h50;
			3'd5:    v = 8'h60;
			default: v = 8'h70;
		endcase
		return v;
	endfunction

endpackage

>>> src/mte_event_pack.sv
// Combinational packer: turns one registered note event into its track event bytes.
// Depends on mte_pkg.
`timescale 1ns / 1ps

module mte_event_pack (
	input  mte_pkg::item_t      item,
	input  logic [31:0]         last_time,
	input  mte_pkg::drum_notes_t drum_notes,
	output mte_pkg::pack_t      pk
);

	logic [31:0] delta;
	logic [4:0][7:0] vlq;
	logic [3:0]  nv;
	logic [7:0]  status;
	logic [7:0]  note;
	logic [7:0]  vel;
	logic [2:0]  amp_sat;

	// Split the delta into 4/7/7/7/7-bit groups, continuation bit on all but the last
	assign delta  = 32'(item.event_time) - last_time;
	assign vlq[0] = {4'b1000, delta[31:28]};
	assign vlq[1] = {1'b1, delta[27:21]};
	assign vlq[2] = {1'b1, delta[20:14]};
	assign vlq[3] = {1'b1, delta[13:7]};
	assign vlq[4] = {1'b0, delta[6:0]};

	// Count delta bytes, dropping leading zero groups; a zero delta gives one 0 byte
	always_comb begin
		if (delta[31:28] != 4'd0) begin
			nv = 4'd5;
		end else if (delta[27:21] != 7'd0) begin
			nv = 4'd4;
		end else if (delta[20:14] != 7'd0) begin
			nv = 4'd3;
		end else if (delta[13:7] != 7'd0) begin
			nv = 4'd2;
		end else begin
			nv = 4'd1;
		end
	end

	// Status and note: drum channel with per-color note, or melodic note with range check
	always_comb begin
		if (item.sampled) begin
			status = item.status_base + mte_pkg::DRUM_CHANNEL;
			if (item.color < 4'(mte_pkg::NumDrum)) begin
				note = drum_notes[item.color[2:0]];
			end else begin
				note = mte_pkg::DRUM_NONE;
			end
		end else begin
			status = item.status_base + {4'd0, item.color};
			if (8'(item.note_number) <= mte_pkg::NOTE_MAX) begin
				note = 8'(item.note_number);
			end else begin
				note = mte_pkg::NOTE_DEFAULT;
			end
		end
	end

	// Velocity: zero for note off, else saturated table lookup
	assign amp_sat = (item.amplitude > mte_pkg::AMP_MAX) ? mte_pkg::AMP_MAX : item.amplitude;
	assign vel = (item.status_base == mte_pkg::STATUS_NOTE_OFF) ? 8'h00
	           : mte_pkg::velocity(amp_sat);

	// Place delta bytes first, then status, note and velocity
	always_comb begin
		pk.cnt = mte_pkg::CntW'(nv + 4'd3);
		for (int j = 0; j < mte_pkg::MaxBytes; j++) begin
			if (4'(j) < nv) begin
				pk.bytes[j] = vlq[3'(4'(j) + 4'd5 - nv)];
			end else if (4'(j) == nv) begin
				pk.bytes[j] = status;
			end else if (4'(j) == nv + 4'd1) begin
				pk.bytes[j] = note;
			end else begin
				pk.bytes[j] = vel;
			end
		end
	end

endmodule

>>> src/midi_track_event_encoder.sv
// MIDI track event encoder: input register, event packer and byte serializer.
// Depends on mte_pkg and mte_event_pack.
//
// Usage: note events arrive on the in_valid/in_ready channel, one event per transfer.
// Each event leaves as 4 to 8 bytes on the out_valid/out_ready channel: the delta time
// as a variable-length quantity (1 to 5 bytes), then status, note and velocity. The
// velocity byte carries last = 1. track_length is one more than the bytes sent since reset.
// Configuration is written through cfg_we/cfg_index/cfg_data, one register per cycle.
// The user writes it only while the block is idle; the block does not enforce this.
// Index 0 is enable, indexes 1 to 7 are the drum notes. An event waits in the input
// register while the serializer is busy, then is packed and loaded into the byte buffer.
// Throughput: one byte per cycle while the receiver accepts; an event occupies the byte
// serializer until its last byte transfers, and the next event is packed during the
// final byte so bytes of consecutive events follow with no gap. While the serializer is
// busy one further event waits in the input register and in_ready drops.
// Disabled: events are taken at one per cycle and dropped without output.
// Reset clears enable and the last event time, sets the byte count to 1 and loads
// the default drum notes. When the receiver stalls, the current byte holds and the
// input side stops after one buffered event.
`timescale 1ns / 1ps

module midi_track_event_encoder (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	// event input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         status_base,
	input  logic [3:0]         color,
	input  logic               sampled,
	input  logic signed [31:0] event_time,
	input  logic signed [7:0]  note_number,
	input  logic [2:0]         amplitude,
	// byte output
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               last,
	output logic [31:0]        track_length
);

	logic                          enable_q;
	mte_pkg::drum_notes_t          drum_q;
	logic [31:0]                   last_time_q;
	logic                          valid_s1;
	mte_pkg::item_t                item_s1;
	mte_pkg::pack_t                pk;
	mte_pkg::byte_vec_t            buf_q;
	logic [mte_pkg::CntW-1:0]      rem_q;
	logic [31:0]                   tl_q;
	logic                          out_xfer;
	logic                          ser_free;
	logic                          s1_take;
	logic                          load;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			drum_q   <= mte_pkg::DRUM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == mte_pkg::REG_ENABLE) begin
				enable_q <= cfg_data[0];
			end else begin
				drum_q[cfg_index - mte_pkg::REG_DRUM_FIRST] <= cfg_data;
			end
		end
	end

	// Handshake control
	assign out_xfer = out_valid && out_ready;
	assign ser_free = (rem_q == '0) || ((rem_q == mte_pkg::CntW'(1)) && out_ready);
	assign s1_take  = valid_s1 && (!enable_q || ser_free);
	assign load     = valid_s1 && enable_q && ser_free;
	assign in_ready = !valid_s1 || s1_take;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{status_base, color, sampled, event_time, note_number, amplitude};
		end
	end

	mte_event_pack u_pack (
		.item       (item_s1),
		.last_time  (last_time_q),
		.drum_notes (drum_q),
		.pk         (pk)
	);

	// Serializer control and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			last_time_q <= '0;
			tl_q        <= 32'd1;
		end else begin
			if (load) begin
				rem_q       <= pk.cnt;
				last_time_q <= 32'(item_s1.event_time);
			end else if (out_xfer) begin
				rem_q <= rem_q - mte_pkg::CntW'(1);
			end
			if (out_xfer) begin
				tl_q <= tl_q + 32'd1;
			end
		end
	end

	// Byte buffer: load a packed event, advance one byte per transfer
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= pk.bytes;
		end else if (out_xfer) begin
			for (int i = 0; i < mte_pkg::MaxBytes - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

	assign out_valid    = (rem_q != '0);
	assign out_byte     = buf_q[0];
	assign last         = (rem_q == mte_pkg::CntW'(1));
	assign track_length = tl_q;

endmodule

>>> src/mte_checker.sv
// Port-level checker for the MIDI track event encoder, bound to the top level.
// Depends on midi_track_event_encoder's port list only.
`timescale 1ns / 1ps

module mte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        last,
	input logic [31:0] track_length
);

	// Hold the byte and its count while the receiver stalls
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(track_length))
		else $error("output byte changed while stalled");

	// Bytes of one event follow each other without a gap
	a_event_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside an event");

	// Each transfer advances the running byte count by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid || track_length == $past(track_length) + 32'd1)
		else $error("track length did not advance by one");

endmodule

bind midi_track_event_encoder mte_checker u_mte_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_byte     (out_byte),
	.last         (last),
	.track_length (track_length)
);
